// File: rtl/core/toroidal_life_grid_engine_macros.svh
// Assertion macros for the life grid engine.
`ifndef TOROIDAL_LIFE_GRID_ENGINE_MACROS_SVH
`define TOROIDAL_LIFE_GRID_ENGINE_MACROS_SVH
`ifndef SYNTH
`define TLGE_ASSERT(lbl, ck, rst_n, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) \
		else $error("tlge check failed");
`define TLGE_ASSERT_ALWAYS(lbl, ck, prop) \
	lbl: assert property (@(posedge ck) prop) else $error("tlge check failed");
`else
`define TLGE_ASSERT(lbl, ck, rst_n, prop)
`define TLGE_ASSERT_ALWAYS(lbl, ck, prop)
`endif
`endif

// File: rtl/core/tlge_pkg.sv
`timescale 1ns / 1ps
package tlge_pkg;
	localparam logic [2:0] FN_READ  = 3'd0;
	localparam logic [2:0] FN_WRITE = 3'd1;
	localparam logic [2:0] FN_RECT  = 3'd2;
	localparam logic [2:0] FN_FILL  = 3'd3;
	localparam logic [2:0] FN_STEP  = 3'd4;

	typedef struct packed {
		logic [2:0] func;
		logic [5:0] col;
		logic [5:0] row;
		logic [6:0] rect_width;
		logic [6:0] rect_height;
		logic       cell_in;
	} in_t;

	typedef struct packed {
		logic cell_out;
		logic status;
	} out_t;
endpackage

// File: rtl/core/toroidal_life_grid_engine.sv
`timescale 1ns / 1ps
// Toroidal life grid engine: a GRID_SIDE by GRID_SIDE grid of one-bit cells
// kept as one memory row per grid row. One operation word in, one result word
// out. A rectangle write does one read-modify-write of the memory row for
// each covered row, a fill writes every row, and a generation step streams
// rows through a three-row window: each new row is written back in place
// while the read port runs ahead. After reset a clearing pass writes every
// row to zero before the first operation is taken. A result waits in an
// output register; the next operation is taken meanwhile.
`include "toroidal_life_grid_engine_macros.svh"
module toroidal_life_grid_engine
	import tlge_pkg::*;
#(
	parameter int GRID_SIDE = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);
	localparam int AW = $clog2(GRID_SIDE);
	localparam int SW = $clog2(GRID_SIDE + 128) + 1;
	localparam logic [SW-1:0] SIDE = SW'(GRID_SIDE);

	typedef enum logic [2:0] {
		ST_CLR, ST_IDLE, ST_ISS, ST_RD, ST_FILL, ST_STEP, ST_DONE
	} state_t;

	state_t          state_q;
	logic [SW-1:0]   cnt_q;
	logic [SW-1:0]   r_q, rend_q, lo_q, hi_q;
	logic            is_read_q, v_q;
	out_t            res_q;
	logic            out_valid_q;
	out_t            out_q;
	logic [GRID_SIDE-1:0] up_q, mid_q, first_q;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr, ram_raddr;
	logic [GRID_SIDE-1:0] ram_wdata, ram_rdata;
	logic [GRID_SIDE-1:0] mask, dn, life_row;
	logic [SW-1:0]        col_w, row_w, rw_w, rh_w;

	assign col_w = SW'(in_data.col);
	assign row_w = SW'(in_data.row);
	assign rw_w  = SW'(in_data.rect_width);
	assign rh_w  = SW'(in_data.rect_height);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		for (int i = 0; i < GRID_SIDE; i++) begin
			mask[i] = (SW'(i) >= lo_q) && (SW'(i) < hi_q);
		end
	end

	assign dn = (cnt_q == SIDE + SW'(2)) ? first_q : ram_rdata;

	always_comb begin
		logic [3:0] n;
		int l, r;
		for (int i = 0; i < GRID_SIDE; i++) begin
			l = (i == 0) ? GRID_SIDE - 1 : i - 1;
			r = (i == GRID_SIDE - 1) ? 0 : i + 1;
			n = 4'(up_q[l]) + 4'(up_q[i]) + 4'(up_q[r]) + 4'(mid_q[l])
				+ 4'(mid_q[r]) + 4'(dn[l]) + 4'(dn[i]) + 4'(dn[r]);
			life_row[i] = (n == 4'd3) || ((n == 4'd2) && mid_q[i]);
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = r_q[AW-1:0];
		ram_wdata = (ram_rdata & ~mask) | (mask & {GRID_SIDE{v_q}});
		ram_raddr = r_q[AW-1:0];
		case (state_q)
			ST_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q[AW-1:0];
				ram_wdata = '0;
			end
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q[AW-1:0];
				ram_wdata = {GRID_SIDE{v_q}};
			end
			ST_RD: begin
				ram_we = !is_read_q;
			end
			ST_STEP: begin
				// read runs two rows ahead of the row written back
				ram_raddr = (cnt_q == '0) ? AW'(GRID_SIDE - 1) : AW'(cnt_q - SW'(1));
				ram_we    = (cnt_q >= SW'(3));
				ram_waddr = AW'(cnt_q - SW'(3));
				ram_wdata = life_row;
			end
			default: ;
		endcase
	end

	tlge_ram #(.WIDTH(GRID_SIDE), .DEPTH(GRID_SIDE)) u_grid (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_STEP) begin
			if (cnt_q == SW'(1)) begin
				up_q <= ram_rdata;
			end else if (cnt_q == SW'(2)) begin
				mid_q   <= ram_rdata;
				first_q <= ram_rdata;
			end else if (cnt_q >= SW'(3)) begin
				up_q  <= mid_q;
				mid_q <= ram_rdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			cnt_q       <= '0;
			r_q         <= '0;
			rend_q      <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			is_read_q   <= 1'b0;
			v_q         <= 1'b0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					cnt_q <= cnt_q + SW'(1);
					if (cnt_q == SIDE - SW'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						cnt_q     <= '0;
						v_q       <= in_data.cell_in;
						r_q       <= row_w;
						lo_q      <= col_w;
						is_read_q <= (in_data.func == FN_READ);
						case (in_data.func)
							FN_READ, FN_WRITE: begin
								hi_q   <= col_w + SW'(1);
								rend_q <= row_w + SW'(1);
								if (col_w >= SIDE || row_w >= SIDE) begin
									res_q   <= '{cell_out: 1'b0, status: 1'b1};
									state_q <= ST_DONE;
								end else begin
									res_q   <= '0;
									state_q <= ST_ISS;
								end
							end
							FN_RECT: begin
								hi_q   <= col_w + rw_w;
								rend_q <= row_w + rh_w;
								if (col_w + rw_w > SIDE || row_w + rh_w > SIDE) begin
									res_q   <= '{cell_out: 1'b0, status: 1'b1};
									state_q <= ST_DONE;
								end else if (rw_w != '0 && rh_w != '0) begin
									res_q   <= '0;
									state_q <= ST_ISS;
								end else begin
									res_q   <= '0;
									state_q <= ST_DONE;
								end
							end
							FN_FILL: begin
								res_q   <= '0;
								state_q <= ST_FILL;
							end
							FN_STEP: begin
								res_q   <= '0;
								state_q <= ST_STEP;
							end
							default: begin
								res_q   <= '0;
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_ISS: begin
					state_q <= ST_RD;
				end
				ST_RD: begin
					if (is_read_q) begin
						res_q.cell_out <= |(ram_rdata & mask);
						state_q        <= ST_DONE;
					end else begin
						r_q     <= r_q + SW'(1);
						state_q <= (r_q + SW'(1) == rend_q) ? ST_DONE : ST_ISS;
					end
				end
				ST_FILL: begin
					cnt_q <= cnt_q + SW'(1);
					if (cnt_q == SIDE - SW'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_STEP: begin
					cnt_q <= cnt_q + SW'(1);
					if (cnt_q == SIDE + SW'(2)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold the result until the output register frees up
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_q       <= res_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`TLGE_ASSERT(a_no_write_idle, clk, arst_n, !(ram_we && in_ready))
	`TLGE_ASSERT(a_step_no_overlap, clk, arst_n,
		(ram_we && state_q == ST_STEP) |-> (ram_waddr != ram_raddr))
	`TLGE_ASSERT(a_result_from_done, clk, arst_n,
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
endmodule

// File: rtl/core/tlge_ram.sv
`timescale 1ns / 1ps
module tlge_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule
